// ===== hw/rtl/rle8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// RLE8 decoder package
// Parse phases, result kinds, fixed BMP header and palette constants and RLE8 escape codes.
// ----------------------------------------------------------------------------
package rle8dec_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_PALETTE = 3'd2,
    PH_CODE1   = 3'd3,
    PH_CODE2   = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_RUN    = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_DELTA  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [7:0]  SIG_B         = 8'h42;
  localparam logic [7:0]  SIG_M         = 8'h4D;
  localparam logic [7:0]  INFO_SIZE     = 8'd40;
  localparam logic [7:0]  DEPTH_8BPP    = 8'd8;
  localparam logic [7:0]  COMP_RLE8     = 8'd1;
  localparam logic [7:0]  ESC_EOL       = 8'd0;
  localparam logic [7:0]  ESC_EOF       = 8'd1;
  localparam logic [7:0]  ESC_DELTA     = 8'd2;
  localparam logic [31:0] HEADER_LAST   = 32'd53;
  localparam logic [31:0] PALETTE_BYTES = 32'd1024;
  localparam logic [32:0] PALETTE_SPAN  = 33'd1024;

endpackage

// ===== hw/rtl/bmp_rle8_to_rgb565_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 to RGB565 decoder unit
// Parses a BMP byte stream, builds an RGB565 palette memory and turns RLE8
// codes into pixel runs at linear frame addresses.
// ----------------------------------------------------------------------------
// A result is registered in stage 1 together with its palette memory read,
// then in the output register, where it waits until it is taken. Throughput:
// one byte per cycle while stage 1 can advance; stream_ready drops while a
// result in stage 1 is blocked by a full, untaken output register.
// Reset clears all parse state; the palette memory is not cleared, since every
// file writes all 256 entries before any pixel code is decoded.
// ----------------------------------------------------------------------------
module bmp_rle8_to_rgb565_decoder_unit
  import rle8dec_pkg::*;
#(
  parameter int MAX_WIDTH       = 2048,
  parameter int MAX_HEIGHT      = 2048,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               stream_valid,
  output logic               stream_ready,
  input  logic [7:0]         stream_byte,
  input  logic               file_start,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         result_kind,
  output logic signed [22:0] run_address,
  output logic [7:0]         run_length,
  output logic [15:0]        pixel_color,
  output logic [22:0]        pixel_total
);

  // Widths of the dimension values once the header has been accepted.
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = (WW + HW > 23) ? (WW + HW) : 23;
  localparam int AW = $clog2(PALETTE_ENTRIES);

  // Parse state.
  phase_t      phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] img_offset, img_offset_next;
  logic [31:0] img_width, img_width_next;
  logic [31:0] img_height, img_height_next;
  logic        hdr_valid, hdr_valid_next;
  logic [23:0] staging, staging_next;
  logic [7:0]  first_code, first_code_next;
  logic [7:0]  lit_left, lit_left_next;
  logic        pad_pending, pad_pending_next;
  logic [22:0] wr_addr, wr_addr_next;

  // Dimension products, refreshed every cycle from the stored header fields.
  // The height is complete at header byte 25, so both are settled long before
  // the header ends at byte 53.
  logic [31:0]   hmag;
  logic [PW-1:0] prod_total, prod_start;
  logic [22:0]   total_q, start_q;

  // Palette memory with a registered read port.
  logic [15:0]   pal_mem [PALETTE_ENTRIES];
  logic [15:0]   pal_rdata;
  logic          pal_we, pal_re;
  logic [AW-1:0] pal_waddr;
  logic [15:0]   pal_wdata;

  // Pipeline: s1 waits for the palette read, then the output register.
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [22:0] s1_addr;
  logic [7:0]  s1_len;
  logic [22:0] s1_total;
  logic        s1_adv, accept;

  // Result of the byte under decode.
  logic        em_valid;
  logic [1:0]  em_kind;
  logic [22:0] em_addr;
  logic [7:0]  em_len;
  logic [22:0] em_total;

  // A file_start byte sees the restart values instead of the stored state.
  phase_t      phase_eff;
  logic [31:0] pos_eff, ppos;
  logic        hv_eff, height_pos, skip_more;

  assign s1_adv       = s1_valid && (!result_valid || result_ready);
  assign stream_ready = !s1_valid || s1_adv;
  assign accept       = stream_valid && stream_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hmag    <= '0;
      total_q <= '0;
      start_q <= '0;
    end else begin
      hmag    <= img_height[31] ? (~img_height + 32'd1) : img_height;
      total_q <= prod_total[22:0];
      start_q <= prod_start[22:0];
    end
  end

  assign prod_total = PW'(hmag[HW-1:0]) * PW'(img_width[WW-1:0]);
  assign prod_start = PW'(hmag[HW-1:0] - HW'(1)) * PW'(img_width[WW-1:0]);

  // A positive, nonzero height means lines are stored bottom-up.
  assign height_pos = !img_height[31] && (img_height != 32'd0);

  always_comb begin
    phase_eff = file_start ? PH_HEADER : phase;
    pos_eff   = file_start ? 32'd0 : pos;
    hv_eff    = file_start ? 1'b1 : hdr_valid;

    phase_next       = phase_eff;
    pos_next         = pos_eff;
    img_offset_next  = file_start ? 32'd0 : img_offset;
    img_width_next   = file_start ? 32'd0 : img_width;
    img_height_next  = file_start ? 32'd0 : img_height;
    hdr_valid_next   = hv_eff;
    staging_next     = file_start ? 24'd0 : staging;
    first_code_next  = file_start ? 8'd0 : first_code;
    lit_left_next    = file_start ? 8'd0 : lit_left;
    pad_pending_next = file_start ? 1'b0 : pad_pending;
    wr_addr_next     = file_start ? 23'd0 : wr_addr;

    em_valid  = 1'b0;
    em_kind   = KIND_RUN;
    em_addr   = '0;
    em_len    = '0;
    em_total  = '0;
    pal_we    = 1'b0;
    pal_waddr = '0;
    pal_wdata = '0;

    skip_more = ({1'b0, pos_eff} + PALETTE_SPAN) < {1'b0, img_offset};
    ppos      = (phase_eff == PH_SKIP) ? 32'd0 : pos_eff;

    unique case (phase_eff)
      PH_HEADER: begin
        // Field checks and little-endian field capture by header position.
        unique case (pos_eff[5:0])
          6'd0:  if (stream_byte != SIG_B) hdr_valid_next = 1'b0;
          6'd1:  if (stream_byte != SIG_M) hdr_valid_next = 1'b0;
          6'd14: if (stream_byte != INFO_SIZE) hdr_valid_next = 1'b0;
          6'd28: if (stream_byte != DEPTH_8BPP) hdr_valid_next = 1'b0;
          6'd30: if (stream_byte != COMP_RLE8) hdr_valid_next = 1'b0;
          6'd15, 6'd16, 6'd17, 6'd29, 6'd31, 6'd32, 6'd33:
            if (stream_byte != 8'd0) hdr_valid_next = 1'b0;
          6'd10: img_offset_next[7:0]   = stream_byte;
          6'd11: img_offset_next[15:8]  = stream_byte;
          6'd12: img_offset_next[23:16] = stream_byte;
          6'd13: img_offset_next[31:24] = stream_byte;
          6'd18: img_width_next[7:0]    = stream_byte;
          6'd19: img_width_next[15:8]   = stream_byte;
          6'd20: img_width_next[23:16]  = stream_byte;
          6'd21: img_width_next[31:24]  = stream_byte;
          6'd22: img_height_next[7:0]   = stream_byte;
          6'd23: img_height_next[15:8]  = stream_byte;
          6'd24: img_height_next[23:16] = stream_byte;
          6'd25: img_height_next[31:24] = stream_byte;
          default: ;
        endcase
        pos_next = pos_eff + 32'd1;
        if (pos_eff == HEADER_LAST) begin
          if (!hv_eff || img_width > 32'(MAX_WIDTH) || hmag > 32'(MAX_HEIGHT)) begin
            phase_next = PH_DONE;
            em_valid   = 1'b1;
            em_kind    = KIND_REJECT;
          end else begin
            phase_next   = PH_SKIP;
            wr_addr_next = height_pos ? start_q : 23'd0;
          end
        end
      end
      PH_SKIP, PH_PALETTE: begin
        if (phase_eff == PH_SKIP && skip_more) begin
          pos_next = pos_eff + 32'd1;
        end else begin
          // Palette entries arrive as blue, green, red, reserved.
          unique case (ppos[1:0])
            2'd0: staging_next = {16'd0, stream_byte};
            2'd1: staging_next[15:8] = stream_byte;
            2'd2: staging_next[23:16] = stream_byte;
            2'd3: begin
              pal_we    = 1'b1;
              pal_waddr = ppos[AW+1:2];
              pal_wdata = {staging[23:19], staging[15:10], staging[7:3]};
            end
            default: ;
          endcase
          pos_next   = ppos + 32'd1;
          phase_next = (ppos >= PALETTE_BYTES - 32'd1) ? PH_CODE1 : PH_PALETTE;
        end
      end
      PH_CODE1: begin
        first_code_next = stream_byte;
        phase_next      = PH_CODE2;
      end
      PH_CODE2: begin
        phase_next = PH_CODE1;
        if (first_code != 8'd0) begin
          // Encoded run: count, then palette index.
          em_valid     = 1'b1;
          em_addr      = wr_addr;
          em_len       = first_code;
          wr_addr_next = wr_addr + 23'(first_code);
        end else if (stream_byte == ESC_EOL) begin
          if (height_pos) begin
            wr_addr_next = wr_addr - {img_width[21:0], 1'b0};
          end
        end else if (stream_byte == ESC_EOF || stream_byte == ESC_DELTA) begin
          phase_next = PH_DONE;
          em_valid   = 1'b1;
          em_kind    = (stream_byte == ESC_EOF) ? KIND_END : KIND_DELTA;
          em_total   = total_q;
        end else begin
          lit_left_next    = stream_byte;
          pad_pending_next = stream_byte[0];
          phase_next       = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        em_valid      = 1'b1;
        em_addr       = wr_addr;
        em_len        = 8'd1;
        wr_addr_next  = wr_addr + 23'd1;
        lit_left_next = lit_left - 8'd1;
        if (lit_left == 8'd1) begin
          phase_next = pad_pending ? PH_PAD : PH_CODE1;
        end
      end
      PH_PAD: begin
        pad_pending_next = 1'b0;
        phase_next       = PH_CODE1;
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  // The palette index of a pixel byte is the stream byte itself.
  assign pal_re = accept && em_valid && (em_kind == KIND_RUN);

  always_ff @(posedge clk) begin
    if (accept && pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
    if (pal_re) begin
      pal_rdata <= pal_mem[stream_byte[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      pos         <= '0;
      img_offset  <= '0;
      img_width   <= '0;
      img_height  <= '0;
      hdr_valid   <= 1'b1;
      staging     <= '0;
      first_code  <= '0;
      lit_left    <= '0;
      pad_pending <= 1'b0;
      wr_addr     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      pos         <= pos_next;
      img_offset  <= img_offset_next;
      img_width   <= img_width_next;
      img_height  <= img_height_next;
      hdr_valid   <= hdr_valid_next;
      staging     <= staging_next;
      first_code  <= first_code_next;
      lit_left    <= lit_left_next;
      pad_pending <= pad_pending_next;
      wr_addr     <= wr_addr_next;
    end
  end

  // Stage 1 holds a result while its palette read completes; the read port is
  // only enabled on accept, so the read data holds while this stage stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= em_valid;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= em_kind;
      s1_addr  <= em_addr;
      s1_len   <= em_len;
      s1_total <= em_total;
    end
  end

  // Output register: holds a finished transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_kind <= s1_kind;
      run_address <= s1_addr;
      run_length  <= s1_len;
      pixel_color <= (s1_kind == KIND_RUN) ? pal_rdata : 16'd0;
      pixel_total <= s1_total;
    end
  end

endmodule

// ===== verif/bmp_rle8_to_rgb565_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 to RGB565 decoder unit testbench
// Streams BMP bytes into the decoder and predicts every pixel run, end of image
// and header rejection with a cycle-free model of the parser. Each result is
// checked against the oldest prediction. One full bottom-up file, with skipped
// bytes before its palette, carries directed codes and then random codes under
// a long receiver hold-off and four idling patterns. Trailing bytes after the
// end, a restart inside a header and broken or oversized headers follow.
// ----------------------------------------------------------------------------
module bmp_rle8_to_rgb565_decoder_unit_tb;
  import rle8dec_pkg::*;

  // The decoder is built with its default size limits, and the model uses
  // the same limits.
  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;

  // Layout of the 54-byte BMP header as seen by the parser.
  localparam int HDR_BYTES  = 54;
  localparam int PAL_BYTES  = 1024;
  localparam int OFS_DATA   = 10;
  localparam int OFS_INFO   = 14;
  localparam int OFS_WIDTH  = 18;
  localparam int OFS_HEIGHT = 22;
  localparam int OFS_DEPTH  = 28;
  localparam int OFS_COMP   = 30;

  // An RLE8 escape starts with a zero count byte.
  localparam logic [7:0] ESC_MARK = 8'd0;

  localparam int     HOLD_CYCLES    = 400;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     HOLD_CODES     = 10;
  localparam int     CODES_PER_MODE = 6;
  localparam longint TIMEOUT_UNITS  = 400_000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [22:0] addr;
    logic [7:0]  len;
    logic [15:0] color;
    logic [22:0] total;
  } decoded_t;

  logic               clk;
  logic               rst;
  logic               stream_valid;
  logic               stream_ready;
  logic [7:0]         stream_byte;
  logic               file_start;
  logic               result_valid;
  logic               result_ready;
  logic [1:0]         result_kind;
  logic signed [22:0] run_address;
  logic [7:0]         run_length;
  logic [15:0]        pixel_color;
  logic [22:0]        pixel_total;

  bmp_rle8_to_rgb565_decoder_unit #(
    .MAX_WIDTH       (MAX_W),
    .MAX_HEIGHT      (MAX_H),
    .PALETTE_ENTRIES (256)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_byte  (stream_byte),
    .file_start   (file_start),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .run_address  (run_address),
    .run_length   (run_length),
    .pixel_color  (pixel_color),
    .pixel_total  (pixel_total)
  );

  // Bytes waiting to be offered, and results predicted but not yet seen.
  stream_item_t byte_q[$];
  decoded_t     decoded_q[$];

  stream_item_t next_item;
  idle_mode_t   idle_mode = IDLE_NONE;
  int           bytes_pushed   = 0;
  int           bytes_offered  = 0;
  int           bytes_accepted = 0;
  int           err_count      = 0;
  int           files_started  = 0;
  int           kind_count[4]  = '{0, 0, 0, 0};
  int           hold_left      = 0;
  int           holds_asked    = 0;
  int           holds_served   = 0;

  // --------------------------------------------------------------------------
  // Parser model state. It mirrors the decoder's architectural state; the
  // palette is only ever read after a file has rewritten all 256 entries.
  // --------------------------------------------------------------------------
  phase_t      dec_phase;
  logic [31:0] dec_pos;
  logic [31:0] dec_offset;
  logic [31:0] dec_width;
  logic [31:0] dec_height;
  logic        dec_hdr_ok;
  logic [15:0] dec_palette [256];
  logic [23:0] dec_staging;
  logic [7:0]  dec_count;
  logic [7:0]  dec_literal_left;
  logic        dec_pad;
  logic [22:0] dec_addr;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic restart_parse();
    dec_phase        = PH_HEADER;
    dec_pos          = '0;
    dec_offset       = '0;
    dec_width        = '0;
    dec_height       = '0;
    dec_hdr_ok       = 1'b1;
    dec_staging      = '0;
    dec_count        = '0;
    dec_literal_left = '0;
    dec_pad          = 1'b0;
    dec_addr         = '0;
  endtask

  function automatic logic [31:0] height_abs();
    return dec_height[31] ? -dec_height : dec_height;
  endfunction

  // True when the height is positive, that is, when lines are stored
  // bottom-up and the write address starts on the last line.
  function automatic logic bottom_up();
    return !dec_height[31] && dec_height != 0;
  endfunction

  // Advances the model by one accepted byte and queues the result it causes.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    decoded_t    res;
    logic        produced;
    logic        checked;
    logic [7:0]  want;
    logic [31:0] prod;
    logic [31:0] dbl;
    res      = '0;
    produced = 1'b0;
    checked  = 1'b1;
    want     = '0;
    if (start) restart_parse();

    // The skip phase either swallows the byte or hands it to the palette
    // as palette byte zero.
    if (dec_phase == PH_SKIP) begin
      if ({32'd0, dec_pos} + 64'(PAL_BYTES) < {32'd0, dec_offset}) begin
        dec_pos = dec_pos + 1;
      end else begin
        dec_phase = PH_PALETTE;
        dec_pos   = '0;
      end
    end

    case (dec_phase)
      PH_HEADER: begin
        case (dec_pos)
          0:          want = SIG_B;
          1:          want = SIG_M;
          OFS_INFO:   want = INFO_SIZE;
          OFS_DEPTH:  want = DEPTH_8BPP;
          OFS_COMP:   want = COMP_RLE8;
          OFS_INFO + 1, OFS_INFO + 2, OFS_INFO + 3, OFS_DEPTH + 1,
          OFS_COMP + 1, OFS_COMP + 2, OFS_COMP + 3: want = 8'd0;
          default:    checked = 1'b0;
        endcase
        if (checked && b != want) dec_hdr_ok = 1'b0;
        if (dec_pos >= OFS_DATA && dec_pos < OFS_DATA + 4)
          dec_offset = dec_offset | (32'(b) << (8 * (dec_pos - OFS_DATA)));
        else if (dec_pos >= OFS_WIDTH && dec_pos < OFS_WIDTH + 4)
          dec_width = dec_width | (32'(b) << (8 * (dec_pos - OFS_WIDTH)));
        else if (dec_pos >= OFS_HEIGHT && dec_pos < OFS_HEIGHT + 4)
          dec_height = dec_height | (32'(b) << (8 * (dec_pos - OFS_HEIGHT)));
        dec_pos = dec_pos + 1;
        if (dec_pos == HDR_BYTES) begin
          if (!dec_hdr_ok || dec_width > 32'(MAX_W) || height_abs() > 32'(MAX_H)) begin
            dec_phase = PH_DONE;
            res.kind  = KIND_REJECT;
            produced  = 1'b1;
          end else begin
            prod      = (dec_height - 32'd1) * dec_width;
            dec_addr  = bottom_up() ? prod[22:0] : '0;
            dec_phase = PH_SKIP;
          end
        end
      end
      PH_PALETTE: begin
        case (dec_pos[1:0])
          2'd0: dec_staging = {16'd0, b};
          2'd1: dec_staging[15:8] = b;
          2'd2: dec_staging[23:16] = b;
          default: begin
            // Blue, green, red then alpha; alpha is dropped.
            dec_palette[dec_pos[9:2]] = {dec_staging[23:19], dec_staging[15:10],
                                         dec_staging[7:3]};
          end
        endcase
        dec_pos = dec_pos + 1;
        if (dec_pos >= PAL_BYTES) dec_phase = PH_CODE1;
      end
      PH_CODE1: begin
        dec_count = b;
        dec_phase = PH_CODE2;
      end
      PH_CODE2: begin
        dec_phase = PH_CODE1;
        if (dec_count != 0) begin
          res.kind  = KIND_RUN;
          res.addr  = dec_addr;
          res.len   = dec_count;
          res.color = dec_palette[b];
          produced  = 1'b1;
          dec_addr  = dec_addr + 23'(dec_count);
        end else if (b == ESC_EOL) begin
          // End of line moves back two lines in bottom-up images.
          if (bottom_up()) begin
            dbl      = dec_width << 1;
            dec_addr = dec_addr - dbl[22:0];
          end
        end else if (b == ESC_EOF || b == ESC_DELTA) begin
          dec_phase = PH_DONE;
          res.kind  = b[1:0];
          prod      = height_abs() * dec_width;
          res.total = prod[22:0];
          produced  = 1'b1;
        end else begin
          dec_literal_left = b;
          dec_pad          = b[0];
          dec_phase        = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        res.kind         = KIND_RUN;
        res.addr         = dec_addr;
        res.len          = 8'd1;
        res.color        = dec_palette[b];
        produced         = 1'b1;
        dec_addr         = dec_addr + 23'd1;
        dec_literal_left = dec_literal_left - 8'd1;
        if (dec_literal_left == 0) dec_phase = dec_pad ? PH_PAD : PH_CODE1;
      end
      PH_PAD: begin
        dec_pad   = 1'b0;
        dec_phase = PH_CODE1;
      end
      default: ;
    endcase
    if (produced) decoded_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d addr %h len %0d color %h total %0d",
                                result_kind, run_address, run_length, pixel_color, pixel_total));
    end else begin
      want = decoded_q.pop_front();
      kind_count[want.kind]++;
      if (result_kind !== want.kind || run_address !== want.addr || run_length !== want.len ||
          pixel_color !== want.color || pixel_total !== want.total)
        report_mismatch($sformatf(
          "got kind %0d addr %h len %0d color %h total %0d, want %0d %h %0d %h %0d",
          result_kind, run_address, run_length, pixel_color, pixel_total,
          want.kind, want.addr, want.len, want.color, want.total));
    end
  endtask

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 50;
      IDLE_BOTH:   return $urandom_range(99) < 14;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 50;
      IDLE_BOTH:     return $urandom_range(99) < 14;
      default:       return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream driver. A byte stays on the bus until its transaction completes;
  // only then may the next one be offered or the bus go idle.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      stream_valid <= 1'b0;
    end else if (!stream_valid || bytes_accepted == bytes_offered) begin
      if (byte_q.size() != 0 && !sender_idles()) begin
        next_item     = byte_q.pop_front();
        stream_valid  <= 1'b1;
        stream_byte   <= next_item.data;
        file_start    <= next_item.start;
        bytes_offered <= bytes_offered + 1;
      end else begin
        stream_valid <= 1'b0;
      end
    end
  end

  // Result ready follows the idling pattern, and is held low throughout a
  // requested hold-off.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  // Counts out the long receiver hold-off on its own.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Results are checked before the byte accepted at the same edge is
  // modeled; the decoder's latency keeps the two independent anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_result();
      if (stream_valid && stream_ready) begin
        decode_byte(stream_byte, file_start);
        bytes_accepted = bytes_accepted + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building blocks. They only fill the byte queue and bump its counters.
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] data, input logic start);
    byte_q.push_back('{data: data, start: start});
    bytes_pushed++;
  endtask

  task automatic queue_pair(input logic [7:0] first, input logic [7:0] second);
    queue_byte(first, 1'b0);
    queue_byte(second, 1'b0);
  endtask

  task automatic queue_noise(input int n_bytes, input logic first_start);
    for (int i = 0; i < n_bytes; i++)
      queue_byte(8'($urandom_range(255)), (i == 0) ? first_start : 1'b0);
  endtask

  // Builds a well-formed header, optionally flipping bits of one byte.
  // Bytes the parser never looks at carry random values.
  task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] off, input int bad_at,
                             input logic [7:0] flip, input logic start);
    logic [7:0] hb [HDR_BYTES];
    for (int i = 0; i < HDR_BYTES; i++) hb[i] = 8'($urandom_range(255));
    hb[0] = SIG_B;
    hb[1] = SIG_M;
    for (int i = 0; i < 4; i++) begin
      hb[OFS_DATA + i]   = off[8*i +: 8];
      hb[OFS_INFO + i]   = (i == 0) ? INFO_SIZE : 8'd0;
      hb[OFS_WIDTH + i]  = w[8*i +: 8];
      hb[OFS_HEIGHT + i] = h[8*i +: 8];
      hb[OFS_COMP + i]   = (i == 0) ? COMP_RLE8 : 8'd0;
    end
    hb[OFS_DEPTH]     = DEPTH_8BPP;
    hb[OFS_DEPTH + 1] = 8'd0;
    if (bad_at >= 0) hb[bad_at] = hb[bad_at] ^ flip;
    files_started++;
    for (int i = 0; i < HDR_BYTES; i++) queue_byte(hb[i], (i == 0) ? start : 1'b0);
  endtask

  // Palette bytes; the first and last entries are all ones and all zeros.
  task automatic send_palette(input int n_bytes);
    logic [7:0] v;
    for (int i = 0; i < n_bytes; i++) begin
      if (i < 4) v = 8'hFF;
      else if (i >= PAL_BYTES - 4) v = 8'h00;
      else v = 8'($urandom_range(255));
      queue_byte(v, 1'b0);
    end
  endtask

  // Well-formed RLE8 codes with random content. A negative end code leaves
  // the image open so that more codes can follow; an end code is followed by
  // up to four bytes that must be ignored.
  task automatic send_codes(input int n_codes, input int end_code);
    int pick;
    int count;
    for (int i = 0; i < n_codes; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        count = ($urandom_range(7) == 0) ? 255 : $urandom_range(1, 255);
        queue_pair(8'(count), 8'($urandom_range(255)));
      end else if (pick < 62) begin
        queue_pair(ESC_MARK, ESC_EOL);
      end else begin
        count = ($urandom_range(5) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
        queue_pair(ESC_MARK, 8'(count));
        queue_noise(count, 1'b0);
        if (count % 2 != 0) queue_noise(1, 1'b0);
      end
    end
    if (end_code >= 0) begin
      queue_pair(ESC_MARK, 8'(end_code));
      queue_noise($urandom_range(4), 1'b0);
    end
  endtask

  task automatic send_file_head(input logic [31:0] w, input logic [31:0] h,
                                input logic [31:0] off, input logic start);
    send_header(w, h, off, -1, 8'h00, start);
    if (off > HDR_BYTES + PAL_BYTES) queue_noise(int'(off) - HDR_BYTES - PAL_BYTES, 1'b0);
    send_palette(PAL_BYTES);
  endtask

  // Waits until every queued byte has been taken and every predicted result
  // has arrived, lets the pipeline settle, then returns on a rising edge.
  task automatic wait_drained();
    @(negedge clk);
    while (bytes_accepted != bytes_pushed || decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  // Header positions whose values the parser checks.
  int checked_at[12] = '{0, 1, OFS_INFO, OFS_INFO + 1, OFS_INFO + 2, OFS_INFO + 3,
                         OFS_DEPTH, OFS_DEPTH + 1, OFS_COMP, OFS_COMP + 1,
                         OFS_COMP + 2, OFS_COMP + 3};

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    stream_valid = 1'b0;
    stream_byte  = 8'd0;
    file_start   = 1'b0;
    result_ready = 1'b0;
    rst          = 1'b1;
    restart_parse();
    for (int i = 0; i < 256; i++) dec_palette[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The first file after reset comes without a start marker and has a few
    // bytes to skip before its palette. A small bottom-up image exercises the
    // longest run, a single pixel, both literal parities, and end-of-line
    // codes that move the address back two lines each.
    send_file_head(32'd3, 32'd2, 32'(HDR_BYTES + PAL_BYTES + 3), 1'b0);
    queue_pair(8'd255, 8'hFF);
    queue_pair(8'd1, 8'h00);
    queue_pair(ESC_MARK, ESC_EOL);
    queue_pair(ESC_MARK, 8'd3);
    queue_noise(4, 1'b0);
    queue_pair(ESC_MARK, 8'd4);
    queue_noise(4, 1'b0);
    repeat (3) queue_pair(ESC_MARK, ESC_EOL);
    queue_pair(8'd2, 8'h80);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering codes, so the
    // decoder backs up into its input. The sender then pauses until every
    // result is in.
    @(negedge clk);
    holds_asked++;
    @(posedge clk);
    send_codes(HOLD_CODES, -1);
    wait_drained();

    // Random codes of the same image under each idling pattern; the last
    // pattern ends the image.
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      send_codes(CODES_PER_MODE, (m == 3) ? int'(ESC_EOF) : -1);
      wait_drained();
    end

    // A restart inside a header, broken headers and sizes just past the
    // limits. The bytes after a rejection must be ignored.
    queue_noise(20, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_header(32'd4, 32'd4, 32'd0, checked_at[$urandom_range(11)],
                  8'($urandom_range(1, 255)), 1'b1);
      queue_noise(4, 1'b0);
    end
    send_header(32'(MAX_W + 1), 32'd1, 32'd0, -1, 8'h00, 1'b1);
    queue_noise(4, 1'b0);
    send_header(32'd1, -32'(MAX_H + 1), 32'd0, -1, 8'h00, 1'b1);
    queue_noise(4, 1'b0);
    wait_drained();

    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", decoded_q.size()));
    $display("Covered %0d bytes in %0d files under four idling patterns and one long hold-off.",
             bytes_accepted, files_started);
    $display("Checked %0d pixel runs, %0d image ends, %0d delta stops, %0d header rejections.",
             kind_count[KIND_RUN], kind_count[KIND_END], kind_count[KIND_DELTA],
             kind_count[KIND_REJECT]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a decoder that hangs or stops returning results.
  initial begin
    #(TIMEOUT_UNITS);
    $display("Timeout with %0d results still outstanding", decoded_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rle8dec_pkg.sv
hw/rtl/bmp_rle8_to_rgb565_decoder_unit.sv
verif/bmp_rle8_to_rgb565_decoder_unit_tb.sv
